>>> src/lfid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_pkg: shared definitions for the lowest freed ID allocator
// Widths, action codes and priority-encoder helpers for the bitmap scan.
// NUM_IDS is a power of two and at least two words of WORD_W bits.
// ----------------------------------------------------------------------------
package lfid_pkg;

   localparam int NUM_IDS    = 256;
   localparam int ID_W       = 9;
   localparam int WORD_W     = 16;
   localparam int NUM_WORDS  = NUM_IDS / WORD_W;
   localparam int BIT_IDX_W  = $clog2(WORD_W);
   localparam int WORD_IDX_W = $clog2(NUM_WORDS);
   localparam int IDX_W      = WORD_IDX_W + BIT_IDX_W;
   localparam int CMP_W      = 17;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

   localparam logic [1:0] ACT_ALLOCATE = 2'd0;
   localparam logic [1:0] ACT_CLAIM    = 2'd1;
   localparam logic [1:0] ACT_RELEASE  = 2'd2;

   // lowest set bit position, 0 for an empty word
   function automatic logic [BIT_IDX_W-1:0] low_bit(input logic [WORD_W-1:0] w);
      logic [BIT_IDX_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

   // highest set bit position, 0 for an empty word
   function automatic logic [BIT_IDX_W-1:0] high_bit(input logic [WORD_W-1:0] w);
      logic [BIT_IDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) begin
            r = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> src/lowest_freed_id_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_freed_id_allocator_unit: ID allocator with freed-ID reuse
// Hands out IDs 1..NUM_IDS from two bitmaps (assigned, freed) kept as
// word memories, scanned one word per cycle by one priority encoder per bitmap.
// ----------------------------------------------------------------------------
//  channel   ports                               transfer
//  --------  ----------------------------------  ---------------------------
//  request   start, busy, req_action, req_id     start && !busy
//  response  rsp_valid, rsp_granted_id,          one-cycle strobe, no stall
//            rsp_status
//
//  Allocate: busy through the scan, pick and (unless full) read-modify-write
//  states; the response shows in the cycle busy drops. The scan reads one
//  word of each bitmap memory per cycle through its single read port, lowest
//  freed and highest assigned in parallel. Claim/release: busy for the
//  read-modify-write state only. Bad ID or unused action: response the next
//  cycle, never busy.
//  Synchronous reset clears the per-word valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module lowest_freed_id_allocator_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic [lfid_pkg::ID_W-1:0] req_id,
   output logic                     rsp_valid,
   output logic [lfid_pkg::ID_W-1:0] rsp_granted_id,
   output logic                     rsp_status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_PICK = 2'd2;
   localparam logic [1:0] ST_RMW  = 2'd3;

   localparam int IDX_W      = lfid_pkg::IDX_W;
   localparam int WORD_W     = lfid_pkg::WORD_W;
   localparam int WORD_IDX_W = lfid_pkg::WORD_IDX_W;
   localparam int BIT_IDX_W  = lfid_pkg::BIT_IDX_W;
   localparam int ID_W       = lfid_pkg::ID_W;
   localparam int CMP_W      = lfid_pkg::CMP_W;

   // bitmap memories and per-word valid bits
   logic [WORD_W-1:0] free_mem [lfid_pkg::NUM_WORDS];
   logic [WORD_W-1:0] asg_mem  [lfid_pkg::NUM_WORDS];
   logic [lfid_pkg::NUM_WORDS-1:0] free_vld_ff, asg_vld_ff;

   logic [WORD_W-1:0] free_rd_ff, asg_rd_ff;
   logic              free_rd_vld_ff, asg_rd_vld_ff;

   logic [1:0]            state_ff, state_in;
   logic [WORD_IDX_W-1:0] cnt_ff, cnt_in;
   logic                  found_free_ff, found_free_in;
   logic                  found_top_ff, found_top_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      top_idx_ff, top_idx_in;
   logic [IDX_W-1:0]      op_idx_ff, op_idx_in;
   logic                  op_claim_ff, op_claim_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [WORD_IDX_W-1:0] free_addr, asg_addr;
   logic                  wr_en;
   logic [WORD_IDX_W-1:0] wr_addr;
   logic [WORD_W-1:0]     free_wr_data, asg_wr_data;

   logic                  accept, in_range;
   logic [IDX_W-1:0]      req_idx;
   logic [WORD_W-1:0]     free_word, asg_word, bit_mask;
   logic [WORD_IDX_W-1:0] asg_cnt, cnt_next;
   logic [IDX_W:0]        top_sum;
   logic [IDX_W-1:0]      pick_idx;

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_range  = (req_id != '0) &&
                      (CMP_W'(req_id) <= CMP_W'(lfid_pkg::NUM_IDS));
   assign req_idx   = IDX_W'(req_id - ID_W'(1));
   assign free_word = free_rd_vld_ff ? free_rd_ff : '0;
   assign asg_word  = asg_rd_vld_ff ? asg_rd_ff : '0;
   assign cnt_next  = cnt_ff + WORD_IDX_W'(1);
   assign asg_cnt   = lfid_pkg::LAST_WORD - cnt_ff;
   assign top_sum   = found_top_ff ? ({1'b0, top_idx_ff} + (IDX_W + 1)'(1)) : '0;
   assign pick_idx  = found_free_ff ? free_idx_ff : top_sum[IDX_W-1:0];
   assign bit_mask  = WORD_W'(1) << op_idx_ff[BIT_IDX_W-1:0];

   // read address selection
   always_comb begin
      free_addr = req_idx[IDX_W-1:BIT_IDX_W];
      asg_addr  = req_idx[IDX_W-1:BIT_IDX_W];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_action == lfid_pkg::ACT_ALLOCATE) begin
               free_addr = '0;
               asg_addr  = lfid_pkg::LAST_WORD;
            end
         end
         ST_SCAN: begin
            free_addr = cnt_next;
            asg_addr  = lfid_pkg::LAST_WORD - cnt_next;
         end
         ST_PICK: begin
            free_addr = pick_idx[IDX_W-1:BIT_IDX_W];
            asg_addr  = pick_idx[IDX_W-1:BIT_IDX_W];
         end
         ST_RMW: begin
            free_addr = op_idx_ff[IDX_W-1:BIT_IDX_W];
            asg_addr  = op_idx_ff[IDX_W-1:BIT_IDX_W];
         end
         default: begin
            free_addr = '0;
            asg_addr  = '0;
         end
      endcase
   end

   assign wr_en        = (state_ff == ST_RMW);
   assign wr_addr      = op_idx_ff[IDX_W-1:BIT_IDX_W];
   assign free_wr_data = op_claim_ff ? (free_word & ~bit_mask) : (free_word | bit_mask);
   assign asg_wr_data  = op_claim_ff ? (asg_word | bit_mask) : (asg_word & ~bit_mask);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= free_wr_data;
         asg_mem[wr_addr]  <= asg_wr_data;
      end
      free_rd_ff <= free_mem[free_addr];
      asg_rd_ff  <= asg_mem[asg_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_vld_ff    <= '0;
         asg_vld_ff     <= '0;
         free_rd_vld_ff <= 1'b0;
         asg_rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            free_vld_ff[wr_addr] <= 1'b1;
            asg_vld_ff[wr_addr]  <= 1'b1;
         end
         free_rd_vld_ff <= free_vld_ff[free_addr];
         asg_rd_vld_ff  <= asg_vld_ff[asg_addr];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      found_free_in = found_free_ff;
      found_top_in  = found_top_ff;
      free_idx_in   = free_idx_ff;
      top_idx_in    = top_idx_ff;
      op_idx_in     = op_idx_ff;
      op_claim_in   = op_claim_ff;
      rsp_valid_in  = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_action == lfid_pkg::ACT_ALLOCATE) begin
                  state_in      = ST_SCAN;
                  cnt_in        = '0;
                  found_free_in = 1'b0;
                  found_top_in  = 1'b0;
               end else if ((req_action == lfid_pkg::ACT_CLAIM ||
                             req_action == lfid_pkg::ACT_RELEASE) && in_range) begin
                  state_in    = ST_RMW;
                  op_idx_in   = req_idx;
                  op_claim_in = (req_action == lfid_pkg::ACT_CLAIM);
               end else if (req_action == lfid_pkg::ACT_CLAIM ||
                            req_action == lfid_pkg::ACT_RELEASE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = req_id;
                  rsp_status_in = 1'b1;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_status_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (!found_free_ff && (free_word != '0)) begin
               found_free_in = 1'b1;
               free_idx_in   = {cnt_ff, lfid_pkg::low_bit(free_word)};
            end
            if (!found_top_ff && (asg_word != '0)) begin
               found_top_in = 1'b1;
               top_idx_in   = {asg_cnt, lfid_pkg::high_bit(asg_word)};
            end
            cnt_in = cnt_next;
            if (cnt_ff == lfid_pkg::LAST_WORD) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // full: nothing freed and the top ID is taken
            if (!found_free_ff && (top_sum == (IDX_W + 1)'(lfid_pkg::NUM_IDS))) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = 1'b1;
            end else begin
               state_in    = ST_RMW;
               op_idx_in   = pick_idx;
               op_claim_in = 1'b1;
            end
         end
         ST_RMW: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_id_in     = ID_W'({1'b0, op_idx_ff} + (IDX_W + 1)'(1));
            rsp_status_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         found_free_ff <= 1'b0;
         found_top_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         found_free_ff <= found_free_in;
         found_top_ff  <= found_top_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff   <= free_idx_in;
      top_idx_ff    <= top_idx_in;
      op_idx_ff     <= op_idx_in;
      op_claim_ff   <= op_claim_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;

   // every pass through the sequencer ends in a response
   a_busy_end_rsp : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_alloc_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == lfid_pkg::ACT_ALLOCATE) |=> busy)
      else $error("allocate transaction did not start a scan");

   a_ok_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |-> (rsp_granted_id != '0))
      else $error("successful response carries ID zero");

endmodule
